>>> src/bcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier package
// Shared types, event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int CfgWidth  = 16;
    localparam int IdxWidth  = 2;
    localparam int AddrWidth = 4;
    localparam int DataWidth = 32;
    localparam int TickWidth = 32;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_LONG   = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_SINGLE = 2'd3
    } t_event;

    localparam logic [IdxWidth-1:0] REG_DEBOUNCE     = 2'd0;
    localparam logic [IdxWidth-1:0] REG_LONG_PRESS   = 2'd1;
    localparam logic [IdxWidth-1:0] REG_DOUBLE_CLICK = 2'd2;

    localparam logic [CfgWidth-1:0] DEBOUNCE_RESET     = 16'd50;
    localparam logic [CfgWidth-1:0] LONG_PRESS_RESET   = 16'd1000;
    localparam logic [CfgWidth-1:0] DOUBLE_CLICK_RESET = 16'd300;

    typedef struct packed {
        logic [CfgWidth-1:0] debounce_ticks;
        logic [CfgWidth-1:0] long_press_ticks;
        logic [CfgWidth-1:0] double_click_ticks;
    } t_cfg;

endpackage

>>> src/bcc_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier state machine
// Holds the phase and the time stamp and classifies one sample per step.
// ----------------------------------------------------------------------------
module bcc_fsm
    import bcc_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_pressed,
    input  logic [TIME_WIDTH-1:0] i_now,
    input  t_cfg                  i_cfg,
    output t_event                o_event
);

    typedef enum logic [1:0] {
        PH_IDLE         = 2'd0,
        PH_PRESSED      = 2'd1,
        PH_WAIT_RELEASE = 2'd2,
        PH_WAIT_DOUBLE  = 2'd3
    } t_phase;

    t_phase                  r_phase;
    t_phase                  n_phase;
    logic [TIME_WIDTH-1:0]   r_stamp;
    logic [TIME_WIDTH-1:0]   n_stamp;
    logic [TIME_WIDTH-1:0]   elapsed;
    logic [TIME_WIDTH+15:0]  debounce_wide;
    logic [TIME_WIDTH+15:0]  long_wide;
    logic [TIME_WIDTH+15:0]  double_wide;
    logic                    debounce_met;
    logic                    long_met;
    logic                    double_met;
    t_event                  n_event;

    always_comb begin
        elapsed       = i_now - r_stamp;
        debounce_wide = {{TIME_WIDTH{1'b0}}, i_cfg.debounce_ticks};
        long_wide     = {{TIME_WIDTH{1'b0}}, i_cfg.long_press_ticks};
        double_wide   = {{TIME_WIDTH{1'b0}}, i_cfg.double_click_ticks};
        debounce_met  = elapsed >= debounce_wide[TIME_WIDTH-1:0];
        long_met      = elapsed >= long_wide[TIME_WIDTH-1:0];
        double_met    = elapsed >= double_wide[TIME_WIDTH-1:0];
    end

    always_comb begin
        n_phase = r_phase;
        n_stamp = r_stamp;
        n_event = EV_NONE;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_pressed) begin
                    n_stamp = i_now;
                    n_phase = PH_PRESSED;
                end
            end
            PH_PRESSED: begin
                if (i_pressed) begin
                    if (long_met) begin
                        n_event = EV_LONG;
                        n_phase = PH_WAIT_RELEASE;
                    end
                end else if (debounce_met) begin
                    n_stamp = i_now;
                    n_phase = PH_WAIT_DOUBLE;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_WAIT_DOUBLE: begin
                if (i_pressed) begin
                    n_event = EV_DOUBLE;
                    n_phase = PH_WAIT_RELEASE;
                end else if (double_met) begin
                    n_event = EV_SINGLE;
                    n_phase = PH_IDLE;
                end
            end
            PH_WAIT_RELEASE: begin
                if (!i_pressed) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign o_event = n_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_stamp <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_stamp <= n_stamp;
        end
    end

    a_long_then_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_event == EV_LONG) |=> r_phase == PH_WAIT_RELEASE)
        else $error("long press did not move to wait for release");

    a_single_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_event == EV_SINGLE) |=> r_phase == PH_IDLE)
        else $error("single click did not return to idle");

    a_hold_without_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_stamp))
        else $error("state changed without a sample");

endmodule

>>> src/button_click_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier
// Classifies polled button samples into long press, double click and single
// click events with configurable debounce, hold and window times.
//
//   Channel  Direction  Handshake               Payload
//   input    in         i_in_valid/o_in_stall   i_pressed, i_now_tick
//   output   out        o_out_valid/i_out_stall o_event_res
//   config   in         APB write/read          debounce, long press, window
//
// One sample is taken per cycle while the input is not stalled; it is held in
// the sample register until its event is handed to the result register.
// Reset is synchronous and active low and restores the default thresholds.
// A stalled output holds its event; the sample register still takes a new
// beat while it is empty or draining into the result register.
// ----------------------------------------------------------------------------
module button_click_classifier_top
    import bcc_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_pressed,
    input  logic [TickWidth-1:0] i_now_tick,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_event_res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output logic                 pready
);

    t_cfg                            r_cfg;
    logic                            r_s1_valid;
    logic                            r_s1_pressed;
    logic [TIME_WIDTH-1:0]           r_s1_now;
    logic                            r_out_valid;
    t_event                          r_out_event;
    logic                            out_free;
    logic                            advance;
    logic                            in_accept;
    logic                            cfg_write;
    logic [IdxWidth-1:0]             cfg_idx;
    logic [TIME_WIDTH+TickWidth-1:0] now_wide;
    t_event                          step_event;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[AddrWidth-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks     <= DEBOUNCE_RESET;
            r_cfg.long_press_ticks   <= LONG_PRESS_RESET;
            r_cfg.double_click_ticks <= DOUBLE_CLICK_RESET;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_DEBOUNCE:     r_cfg.debounce_ticks     <= pwdata[CfgWidth-1:0];
                REG_LONG_PRESS:   r_cfg.long_press_ticks   <= pwdata[CfgWidth-1:0];
                REG_DOUBLE_CLICK: r_cfg.double_click_ticks <= pwdata[CfgWidth-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_DEBOUNCE:     prdata = {16'd0, r_cfg.debounce_ticks};
            REG_LONG_PRESS:   prdata = {16'd0, r_cfg.long_press_ticks};
            REG_DOUBLE_CLICK: prdata = {16'd0, r_cfg.double_click_ticks};
            default:          prdata = '0;
        endcase
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign now_wide   = {{TIME_WIDTH{1'b0}}, i_now_tick};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pressed <= i_pressed;
            r_s1_now     <= now_wide[TIME_WIDTH-1:0];
        end
    end

    bcc_fsm #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_pressed (r_s1_pressed),
        .i_now     (r_s1_now),
        .i_cfg     (r_cfg),
        .o_event   (step_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_event <= step_event;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_out_event;

    a_sample_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> r_s1_valid)
        else $error("held sample was dropped");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_s1_valid)
        else $error("reset did not clear the pipeline");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("processed sample gave no result");

endmodule

>>> verif/tb_button_click_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier testbench
// Feeds poll samples through the valid/stall input channel and checks every
// output beat against an in-bench click state machine model or a fixed table
// event. A short table of hand-picked samples runs at the reset thresholds.
// Phases of random press, release and hold gestures follow, each under new
// thresholds written over APB and read back, including all-zero and all-ones
// thresholds. Both channels idle at random, except in one calm stretch.
// ----------------------------------------------------------------------------
module tb_button_click_classifier_top;
    import bcc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE         = 2'd0,
        ST_PRESSED      = 2'd1,
        ST_WAIT_RELEASE = 2'd2,
        ST_WAIT_DOUBLE  = 2'd3
    } t_phase;

    typedef struct packed {
        logic                 level;
        logic [TickWidth-1:0] tick;
        logic                 fixed;
        t_event               ev;
    } t_row;

    localparam logic [IdxWidth-1:0] REG_UNUSED = 2'd3;

    localparam int DirectedRows = 19;
    localparam int RandomItems  = 1830;
    localparam int PhaseCount   = 6;
    localparam int CalmFirst    = 1200;
    localparam int CalmLast     = 2000;

    localparam t_row DIRECTED_SEQ [DirectedRows] = '{
        '{1'b0, 32'h0000_0000, 1'b1, EV_NONE},
        '{1'b1, 32'hFFFF_FFF0, 1'b1, EV_NONE},
        '{1'b1, 32'h0000_03D7, 1'b0, EV_NONE},
        '{1'b1, 32'h0000_03D8, 1'b1, EV_LONG},
        '{1'b1, 32'h0000_0500, 1'b1, EV_NONE},
        '{1'b0, 32'h0000_0600, 1'b1, EV_NONE},
        '{1'b1, 32'h0000_1000, 1'b1, EV_NONE},
        '{1'b0, 32'h0000_1031, 1'b0, EV_NONE},
        '{1'b0, 32'h0000_1040, 1'b1, EV_NONE},
        '{1'b1, 32'h0000_2000, 1'b1, EV_NONE},
        '{1'b0, 32'h0000_2032, 1'b0, EV_NONE},
        '{1'b0, 32'h0000_215D, 1'b0, EV_NONE},
        '{1'b0, 32'h0000_215E, 1'b1, EV_SINGLE},
        '{1'b1, 32'h7FFF_FFFF, 1'b1, EV_NONE},
        '{1'b1, 32'h8000_0001, 1'b1, EV_NONE},
        '{1'b0, 32'h8000_0100, 1'b0, EV_NONE},
        '{1'b1, 32'h5555_5555, 1'b1, EV_DOUBLE},
        '{1'b0, 32'hAAAA_AAAA, 1'b1, EV_NONE},
        '{1'b1, 32'hFFFF_FFFF, 1'b1, EV_NONE}
    };

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_pressed  = 1'b0;
    logic [TickWidth-1:0] i_now_tick = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_event_res;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [AddrWidth-1:0] paddr   = '0;
    logic [DataWidth-1:0] pwdata  = '0;
    logic [DataWidth-1:0] prdata;
    logic                 pready;

    t_phase               btn_phase   = ST_IDLE;
    logic [TickWidth-1:0] press_stamp = '0;
    t_cfg                 thresholds  = '{DEBOUNCE_RESET, LONG_PRESS_RESET, DOUBLE_CLICK_RESET};
    t_event               event_q [$];
    logic [TickWidth-1:0] tick_now    = '0;
    int                   sent_count  = 0;
    int                   error_count = 0;
    int                   cycle_count = 0;
    logic                 calm;

    assign calm = (cycle_count >= CalmFirst) && (cycle_count < CalmLast);

    button_click_classifier_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pressed   (i_pressed),
        .i_now_tick  (i_now_tick),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_event_res (o_event_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_event classify(input logic level, input logic [TickWidth-1:0] tick);
        logic [TickWidth-1:0] elapsed;
        t_event               ev;
        elapsed = tick - press_stamp;
        ev      = EV_NONE;
        case (btn_phase)
            ST_IDLE: begin
                if (level) begin
                    press_stamp = tick;
                    btn_phase   = ST_PRESSED;
                end
            end
            ST_PRESSED: begin
                if (level) begin
                    if (elapsed >= thresholds.long_press_ticks) begin
                        ev        = EV_LONG;
                        btn_phase = ST_WAIT_RELEASE;
                    end
                end else if (elapsed >= thresholds.debounce_ticks) begin
                    press_stamp = tick;
                    btn_phase   = ST_WAIT_DOUBLE;
                end else begin
                    btn_phase = ST_IDLE;
                end
            end
            ST_WAIT_DOUBLE: begin
                if (level) begin
                    ev        = EV_DOUBLE;
                    btn_phase = ST_WAIT_RELEASE;
                end else if (elapsed >= thresholds.double_click_ticks) begin
                    ev        = EV_SINGLE;
                    btn_phase = ST_IDLE;
                end
            end
            default: begin
                if (!level) begin
                    btn_phase = ST_IDLE;
                end
            end
        endcase
        return ev;
    endfunction

    function automatic logic [TickWidth-1:0] around(input logic [CfgWidth-1:0] limit);
        return TickWidth'(limit) + TickWidth'($urandom_range(0, 2)) - TickWidth'(1);
    endfunction

    task automatic send_sample(input logic level, input logic [TickWidth-1:0] tick,
                               input logic fixed, input t_event fixed_ev);
        t_event ev;
        if (!calm && ($urandom_range(0, 99) < 3)) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pressed  <= level;
        i_now_tick <= tick;
        do @(posedge i_clk); while (o_in_stall);
        ev = classify(level, tick);
        event_q.push_back(fixed ? fixed_ev : ev);
        sent_count++;
    endtask

    task automatic poll(input logic level, input logic [TickWidth-1:0] delta);
        tick_now = tick_now + delta;
        send_sample(level, tick_now, 1'b0, EV_NONE);
    endtask

    task automatic play_gesture();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: begin
                poll(1'b1, $urandom_range(0, 3));
                poll(1'b0, around(thresholds.debounce_ticks));
                poll(1'b0, around(thresholds.double_click_ticks));
                poll(1'b0, 1);
            end
            2, 3, 4: begin
                poll(1'b1, $urandom_range(0, 3));
                poll(1'b0, around(thresholds.debounce_ticks));
                poll(1'b1, $urandom_range(0, thresholds.double_click_ticks));
                poll(1'b1, around(thresholds.long_press_ticks));
                poll(1'b0, 1);
            end
            5, 6: begin
                poll(1'b1, $urandom_range(0, 3));
                repeat ($urandom_range(0, 2)) begin
                    poll(1'b1, $urandom_range(0, thresholds.long_press_ticks / 2));
                end
                poll(1'b1, around(thresholds.long_press_ticks));
                poll(1'b1, 1);
                poll(1'b0, 1);
            end
            7: begin
                poll(1'b1, $urandom_range(0, 3));
                poll(1'b0, $urandom_range(0, thresholds.debounce_ticks));
            end
            default: begin
                repeat ($urandom_range(1, 4)) begin
                    poll(1'($urandom_range(0, 1)), $urandom);
                end
            end
        endcase
    endtask

    task automatic apb_xfer(input logic write, input logic [IdxWidth-1:0] idx,
                            input logic [DataWidth-1:0] wdata,
                            output logic [DataWidth-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= AddrWidth'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [IdxWidth-1:0] idx, input logic [CfgWidth-1:0] value);
        logic [DataWidth-1:0] readback;
        string                reg_name;
        apb_xfer(1'b1, idx, DataWidth'({$urandom, value}), readback);
        case (idx)
            REG_DEBOUNCE: begin
                thresholds.debounce_ticks = value;
                reg_name = "debounce_ticks";
            end
            REG_LONG_PRESS: begin
                thresholds.long_press_ticks = value;
                reg_name = "long_press_ticks";
            end
            default: begin
                thresholds.double_click_ticks = value;
                reg_name = "double_click_ticks";
            end
        endcase
        apb_xfer(1'b0, idx, '0, readback);
        if (readback[CfgWidth-1:0] !== value) begin
            $error("%s mismatch: expected %0d, actual %0d", reg_name, value,
                   readback[CfgWidth-1:0]);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        i_out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end

    always @(posedge i_clk) begin : check_beat
        t_event expected;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (event_q.size() == 0) begin
                $error("event_res mismatch: expected none, actual %0d", o_event_res);
                error_count++;
            end else begin
                expected = event_q.pop_front();
                if (o_event_res !== expected) begin
                    $error("event_res mismatch: expected %0d, actual %0d", expected, o_event_res);
                    error_count++;
                end
            end
        end
    end

    initial begin
        logic [DataWidth-1:0] unused_rd;
        int                   target;
        logic [CfgWidth-1:0]  deb;
        logic [CfgWidth-1:0]  hold;
        logic [CfgWidth-1:0]  win;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DirectedRows; r++) begin
            send_sample(DIRECTED_SEQ[r].level, DIRECTED_SEQ[r].tick,
                        DIRECTED_SEQ[r].fixed, DIRECTED_SEQ[r].ev);
        end

        tick_now = $urandom;
        for (int p = 0; p < PhaseCount; p++) begin
            i_in_valid <= 1'b0;
            while (event_q.size() != 0) @(posedge i_clk);
            repeat (4) @(posedge i_clk);
            case (p)
                0: begin
                    apb_xfer(1'b1, REG_UNUSED, $urandom, unused_rd);
                    {deb, hold, win} = {16'd0, 16'd0, 16'd0};
                end
                1: {deb, hold, win} = {16'hFFFF, 16'hFFFF, 16'hFFFF};
                2: {deb, hold, win} = {DEBOUNCE_RESET, LONG_PRESS_RESET, DOUBLE_CLICK_RESET};
                5: {deb, hold, win} = {CfgWidth'($urandom), CfgWidth'($urandom),
                                       CfgWidth'($urandom)};
                default: begin
                    deb  = CfgWidth'($urandom_range(0, 300));
                    hold = CfgWidth'($urandom_range(0, 3000));
                    win  = CfgWidth'($urandom_range(0, 800));
                end
            endcase
            set_threshold(REG_DEBOUNCE, deb);
            set_threshold(REG_LONG_PRESS, hold);
            set_threshold(REG_DOUBLE_CLICK, win);
            target = sent_count + RandomItems / PhaseCount;
            while (sent_count < target) begin
                play_gesture();
            end
        end

        i_in_valid <= 1'b0;
        while (event_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && event_q.size() == 0) begin
            $display("tb_button_click_classifier_top passed");
        end else begin
            $display("tb_button_click_classifier_top failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("tb_button_click_classifier_top failed");
        $finish;
    end

endmodule

>>> button_click_classifier_top.f
src/bcc_pkg.sv
src/bcc_fsm.sv
src/button_click_classifier_top.sv
verif/tb_button_click_classifier_top.sv
